@@ design/cvdf_pkg.sv @@
// ----------------------------------------------------------------------------
// cvdf_pkg: shared types and constants of the CAN value display formatter
// Holds register codes, reset values, fixed-point scale factors, the display
// command bytes and the digit helper used by the value pipeline.
// ----------------------------------------------------------------------------
package cvdf_pkg;

    localparam int IdWidth    = 11;
    localparam int RawWidth   = 16;
    localparam int ByteWidth  = 8;
    localparam int DigitWidth = 4;
    localparam int ValueWidth = 14;

    localparam int QueueDepthDefault = 2;

    localparam logic [IdWidth-1:0]  SpeedIdReset  = 11'h723;
    localparam logic [IdWidth-1:0]  RangeIdReset  = 11'h7A1;
    localparam logic [RawWidth-1:0] SpeedRawReset = 16'd570;
    localparam logic [RawWidth-1:0] RangeRawReset = 16'd10000;

    localparam logic [ValueWidth-1:0] DisplayMax = 14'd9998;

    // speed = (raw * 36 + 50) / 100, the divide done as a reciprocal multiply
    localparam logic [5:0]  SpeedScale = 6'd36;
    localparam logic [21:0] SpeedRound = 22'd50;
    localparam logic [21:0] SpeedRecip = 22'd2684355;

    // range = |raw| * 328084 / 10^7 = ((|raw| * 328084) >> 7) / 78125
    localparam logic [18:0] RangeScale   = 19'd328084;
    localparam logic [20:0] RangeRecip   = 21'd1759218;
    localparam logic [16:0] RangeDivisor = 17'd78125;

    localparam logic [12:0] Div10Recip = 13'd6554;

    localparam logic [DigitWidth-1:0] BlankDigit = 4'd10;

    localparam logic [ByteWidth-1:0] CmdPrefix = 8'h50;
    localparam logic [ByteWidth-1:0] CmdFour   = 8'h04;
    localparam logic [ByteWidth-1:0] CmdTilde  = 8'h7E;
    localparam logic [ByteWidth-1:0] CmdDigits = 8'h44;

    typedef enum logic {
        REG_SPEED_ID = 1'b0,
        REG_RANGE_ID = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_FRAME   = 1'b0,
        KIND_REFRESH = 1'b1
    } kind_t;

    typedef struct packed {
        logic [RawWidth-1:0] speed_raw;
        logic [RawWidth-1:0] range_raw;
    } snap_t;

    typedef struct packed {
        logic [DigitWidth-1:0] th;
        logic [DigitWidth-1:0] hu;
        logic [DigitWidth-1:0] te;
        logic [DigitWidth-1:0] un;
    } digits_t;

    typedef struct packed {
        digits_t speed;
        digits_t range;
    } disp_t;

    // v / 10 for any 14-bit v below 10240, since the result is 10 bits wide
    function automatic logic [9:0] div10(input logic [ValueWidth-1:0] v);
        logic [26:0] prod;
        prod = 27'(v) * 27'(Div10Recip);
        return prod[25:16];
    endfunction

endpackage

@@ design/cvdf_front.sv @@
// ----------------------------------------------------------------------------
// cvdf_front: input side of the CAN value display formatter
// Holds the identifier registers and the latest raw values, sorts incoming
// items, and hands a snapshot of both raw values to the queue on a refresh.
// ----------------------------------------------------------------------------
module cvdf_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 kind,
    input  logic [cvdf_pkg::IdWidth-1:0]         frame_id,
    input  logic [cvdf_pkg::ByteWidth-1:0]       data_byte_zero,
    input  logic [cvdf_pkg::ByteWidth-1:0]       data_byte_one,
    input  logic [cvdf_pkg::ByteWidth-1:0]       data_byte_six,
    input  logic [cvdf_pkg::ByteWidth-1:0]       data_byte_seven,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [cvdf_pkg::IdWidth-1:0]         cfg_data,
    output logic                                 q_push,
    output cvdf_pkg::snap_t                      q_data,
    input  logic                                 q_full
);

    logic [cvdf_pkg::IdWidth-1:0]  speed_id_reg, speed_id_next;
    logic [cvdf_pkg::IdWidth-1:0]  range_id_reg, range_id_next;
    logic [cvdf_pkg::RawWidth-1:0] speed_raw_reg, speed_raw_next;
    logic [cvdf_pkg::RawWidth-1:0] range_raw_reg, range_raw_next;
    logic                          accept;
    logic                          is_frame;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign is_frame = (kind == cvdf_pkg::KIND_FRAME);
    assign q_push   = accept && (kind == cvdf_pkg::KIND_REFRESH);
    assign q_data   = '{speed_raw: speed_raw_reg, range_raw: range_raw_reg};

    always_comb
    begin
        speed_id_next = speed_id_reg;
        range_id_next = range_id_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                cvdf_pkg::REG_SPEED_ID: speed_id_next = cfg_data;
                cvdf_pkg::REG_RANGE_ID: range_id_next = cfg_data;
                default:                speed_id_next = speed_id_reg;
            endcase
        end
    end

    // speed match wins when both identifiers are equal
    always_comb
    begin
        speed_raw_next = speed_raw_reg;
        range_raw_next = range_raw_reg;
        if (accept && is_frame)
        begin
            if (frame_id == speed_id_reg)
                speed_raw_next = {data_byte_seven, data_byte_six};
            else if (frame_id == range_id_reg)
                range_raw_next = {data_byte_one, data_byte_zero};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_id_reg  <= cvdf_pkg::SpeedIdReset;
            range_id_reg  <= cvdf_pkg::RangeIdReset;
            speed_raw_reg <= cvdf_pkg::SpeedRawReset;
            range_raw_reg <= cvdf_pkg::RangeRawReset;
        end
        else
        begin
            speed_id_reg  <= speed_id_next;
            range_id_reg  <= range_id_next;
            speed_raw_reg <= speed_raw_next;
            range_raw_reg <= range_raw_next;
        end
    end

endmodule

@@ design/cvdf_queue.sv @@
// ----------------------------------------------------------------------------
// cvdf_queue: snapshot queue between the front and the value pipeline
// A small circular buffer of raw-value snapshots, one per refresh.
// ----------------------------------------------------------------------------
module cvdf_queue
#(
    parameter int Depth = cvdf_pkg::QueueDepthDefault
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cvdf_pkg::snap_t wdata,
    output logic            full,
    input  logic            pop,
    output cvdf_pkg::snap_t rdata,
    output logic            empty
);

    localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountWidth = $clog2(Depth + 1);

    cvdf_pkg::snap_t       entry_reg [Depth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == CountWidth'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CountWidth'(do_push) - CountWidth'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

@@ design/cvdf_calc.sv @@
// ----------------------------------------------------------------------------
// cvdf_calc: value pipeline of the CAN value display formatter
// Eight stages turn a raw-value snapshot into the clamped speed and range
// values and then into their decimal digits.
// ----------------------------------------------------------------------------
module cvdf_calc
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cvdf_pkg::snap_t in_data,
    output logic            in_pop,
    output logic            out_valid,
    output cvdf_pkg::disp_t out_data,
    input  logic            out_take
);

    localparam int Stages = 8;
    localparam int Lanes  = 2;

    logic [Stages-1:0] valid_reg, valid_next;
    logic              en;

    // stage 1
    logic [21:0] n_reg, n_next;
    logic [33:0] p_reg, p_next;
    logic [16:0] mag;
    // stage 2
    logic [14:0] qs2_reg, qs2_next;
    logic [10:0] q0_2_reg, q0_2_next;
    logic [26:0] t2_reg;
    logic [43:0] prod_s;
    logic [47:0] prod_r;
    // stage 3
    logic [14:0] qs3_reg;
    logic [10:0] q0_3_reg;
    logic [26:0] t3_reg;
    logic [26:0] m_reg, m_next;
    // stage 4
    logic [cvdf_pkg::ValueWidth-1:0] v4_reg  [Lanes];
    logic [cvdf_pkg::ValueWidth-1:0] v4_next [Lanes];
    logic [26:0]                     rem;
    logic [10:0]                     q_range;
    // stage 5
    logic [cvdf_pkg::ValueWidth-1:0] v5_reg  [Lanes];
    logic [9:0]                      q1_5_reg  [Lanes];
    logic [9:0]                      q1_5_next [Lanes];
    // stage 6
    logic [9:0]                      q1_6_reg  [Lanes];
    logic [3:0]                      un6_reg   [Lanes];
    logic [3:0]                      un6_next  [Lanes];
    logic [6:0]                      q2_6_reg  [Lanes];
    logic [6:0]                      q2_6_next [Lanes];
    logic [cvdf_pkg::ValueWidth-1:0] un_full   [Lanes];
    logic [9:0]                      q2_full   [Lanes];
    // stage 7
    logic [6:0]                      q2_7_reg  [Lanes];
    logic [3:0]                      un7_reg   [Lanes];
    logic [3:0]                      te7_reg   [Lanes];
    logic [3:0]                      te7_next  [Lanes];
    logic [3:0]                      q3_7_reg  [Lanes];
    logic [3:0]                      q3_7_next [Lanes];
    logic [9:0]                      te_full   [Lanes];
    logic [9:0]                      q3_full   [Lanes];
    // stage 8
    cvdf_pkg::digits_t               dig_reg   [Lanes];
    cvdf_pkg::digits_t               dig_next  [Lanes];
    logic [6:0]                      hu_full   [Lanes];

    // the whole pipe holds while a finished result waits for the emitter
    assign en        = !valid_reg[Stages-1] || out_take;
    assign in_pop    = en && in_valid;
    assign out_valid = valid_reg[Stages-1];
    assign out_data  = '{speed: dig_reg[0], range: dig_reg[1]};

    assign valid_next = {valid_reg[Stages-2:0], in_valid};

    // stage 1: scale both raw values
    always_comb
    begin
        mag = in_data.range_raw[cvdf_pkg::RawWidth-1]
            ? 17'h10000 - {1'b0, in_data.range_raw}
            : {1'b0, in_data.range_raw};
        n_next = 22'(in_data.speed_raw) * 22'(cvdf_pkg::SpeedScale) + cvdf_pkg::SpeedRound;
        p_next = 34'(mag) * 34'(cvdf_pkg::RangeScale);
    end

    // stage 2: reciprocal multiplies
    always_comb
    begin
        prod_s    = 44'(n_reg) * 44'(cvdf_pkg::SpeedRecip);
        prod_r    = 48'(p_reg[33:7]) * 48'(cvdf_pkg::RangeRecip);
        qs2_next  = prod_s[42:28];
        q0_2_next = prod_r[47:37];
    end

    // stage 3: back-multiply the range estimate
    assign m_next = 27'(q0_2_reg) * 27'(cvdf_pkg::RangeDivisor);

    // stage 4: correct the range estimate by one, clamp the speed
    always_comb
    begin
        rem        = t3_reg - m_reg;
        q_range    = q0_3_reg + 11'(rem >= 27'(cvdf_pkg::RangeDivisor));
        v4_next[0] = (qs3_reg > 15'(cvdf_pkg::DisplayMax))
                   ? cvdf_pkg::DisplayMax : qs3_reg[cvdf_pkg::ValueWidth-1:0];
        // range stays below the display limit for every 16-bit input
        v4_next[1] = 14'(q_range);
    end

    // stages 5 to 8: divide by ten repeatedly; units in stage 6, tens in stage 7, hundreds and thousands in stage 8
    always_comb
    begin
        for (int i = 0; i < Lanes; i++)
        begin
            q1_5_next[i] = cvdf_pkg::div10(v4_reg[i]);

            un_full[i]   = v5_reg[i] - 14'(q1_5_reg[i]) * 14'd10;
            un6_next[i]  = un_full[i][3:0];
            q2_full[i]   = cvdf_pkg::div10(14'(q1_5_reg[i]));
            q2_6_next[i] = q2_full[i][6:0];

            te_full[i]   = q1_6_reg[i] - 10'(q2_6_reg[i]) * 10'd10;
            te7_next[i]  = te_full[i][3:0];
            q3_full[i]   = cvdf_pkg::div10(14'(q2_6_reg[i]));
            q3_7_next[i] = q3_full[i][3:0];

            hu_full[i]   = q2_7_reg[i] - 7'(q3_7_reg[i]) * 7'd10;
            dig_next[i]  = '{th: q3_7_reg[i], hu: hu_full[i][3:0],
                             te: te7_reg[i], un: un7_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            p_reg    <= p_next;
            qs2_reg  <= qs2_next;
            q0_2_reg <= q0_2_next;
            t2_reg   <= p_reg[33:7];
            qs3_reg  <= qs2_reg;
            q0_3_reg <= q0_2_reg;
            t3_reg   <= t2_reg;
            m_reg    <= m_next;
            for (int i = 0; i < Lanes; i++)
            begin
                v4_reg[i]   <= v4_next[i];
                v5_reg[i]   <= v4_reg[i];
                q1_5_reg[i] <= q1_5_next[i];
                q1_6_reg[i] <= q1_5_reg[i];
                un6_reg[i]  <= un6_next[i];
                q2_6_reg[i] <= q2_6_next[i];
                q2_7_reg[i] <= q2_6_reg[i];
                un7_reg[i]  <= un6_reg[i];
                te7_reg[i]  <= te7_next[i];
                q3_7_reg[i] <= q3_7_next[i];
                dig_reg[i]  <= dig_next[i];
            end
        end
    end

endmodule

@@ design/cvdf_emit.sv @@
// ----------------------------------------------------------------------------
// cvdf_emit: byte sequencer of the CAN value display formatter
// Walks the sixteen command and digit bytes of one refresh into an output
// register that faces the consumer as the head of a queue.
// ----------------------------------------------------------------------------
module cvdf_emit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  cvdf_pkg::disp_t                in_data,
    output logic                           in_take,
    output logic                           empty,
    input  logic                           pop,
    output logic                           display_port,
    output logic [cvdf_pkg::ByteWidth-1:0] out_byte,
    output logic                           last_of_run
);

    logic                           busy_reg, busy_next;
    logic [3:0]                     cnt_reg, cnt_next;
    cvdf_pkg::disp_t                disp_reg, disp_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_port_reg;
    logic [cvdf_pkg::ByteWidth-1:0] out_byte_reg;
    logic                           out_last_reg;
    logic                           load_out;
    logic                           step;
    logic                           finishing;
    cvdf_pkg::digits_t              lane;
    logic [cvdf_pkg::ByteWidth-1:0] byte_sel;
    logic                           th_zero;

    assign empty        = !out_valid_reg;
    assign display_port = out_port_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_run  = out_last_reg;

    assign load_out  = !out_valid_reg || pop;
    assign step      = busy_reg && load_out;
    assign finishing = step && (cnt_reg == 4'd15);
    // take the next display pair while the last byte of this one goes out
    assign in_take   = in_valid && (!busy_reg || finishing);

    always_comb
    begin
        lane    = cnt_reg[3] ? disp_reg.range : disp_reg.speed;
        th_zero = (lane.th == '0);
        case (cnt_reg[2:0])
            3'd0:    byte_sel = cvdf_pkg::CmdPrefix;
            3'd1:    byte_sel = cvdf_pkg::CmdFour;
            3'd2:    byte_sel = cvdf_pkg::CmdTilde;
            3'd3:    byte_sel = cvdf_pkg::CmdDigits;
            3'd4:    byte_sel = 8'(th_zero ? cvdf_pkg::BlankDigit : lane.th);
            3'd5:    byte_sel = 8'((th_zero && lane.hu == '0) ? cvdf_pkg::BlankDigit : lane.hu);
            3'd6:    byte_sel = 8'(lane.te);
            3'd7:    byte_sel = 8'(lane.un);
            default: byte_sel = cvdf_pkg::CmdPrefix;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (in_take)
            busy_next = 1'b1;
        else if (finishing)
            busy_next = 1'b0;
        cnt_next       = step ? cnt_reg + 1'b1 : cnt_reg;
        disp_next      = in_take ? in_data : disp_reg;
        out_valid_next = step ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        disp_reg <= disp_next;
        if (step)
        begin
            out_port_reg <= cnt_reg[3];
            out_byte_reg <= byte_sel;
            out_last_reg <= (cnt_reg == 4'd15);
        end
    end

endmodule

@@ design/can_value_decimal_display_formatter_top.sv @@
// Once a refresh is accepted, its bytes come out one per cycle while the consumer
// pops; the byte sequencer sends sixteen bytes per refresh, and refreshes follow
// each other with no gap when the next display pair is already waiting.
// Frames produce no bytes. The snapshot queue absorbs refreshes
// while the sequencer is busy. Reset (rst_n low) restores the identifier
// registers and raw values to their defaults and empties every stage.
// ----------------------------------------------------------------------------
// can_value_decimal_display_formatter_top: CAN value display formatter
// Tracks speed and range from CAN frames and, on each refresh, sends the
// display command bytes and decimal digits for both displays.
// ----------------------------------------------------------------------------
module can_value_decimal_display_formatter_top
#(
    parameter int QueueDepth = cvdf_pkg::QueueDepthDefault
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           kind,
    input  logic [cvdf_pkg::IdWidth-1:0]   frame_id,
    input  logic [cvdf_pkg::ByteWidth-1:0] data_byte_zero,
    input  logic [cvdf_pkg::ByteWidth-1:0] data_byte_one,
    input  logic [cvdf_pkg::ByteWidth-1:0] data_byte_six,
    input  logic [cvdf_pkg::ByteWidth-1:0] data_byte_seven,
    output logic                           empty,
    input  logic                           pop,
    output logic                           display_port,
    output logic [cvdf_pkg::ByteWidth-1:0] out_byte,
    output logic                           last_of_run,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [cvdf_pkg::IdWidth-1:0]   cfg_data
);

    logic            q_push;
    logic            q_full;
    cvdf_pkg::snap_t q_wdata;
    logic            q_pop;
    logic            q_empty;
    cvdf_pkg::snap_t q_rdata;
    logic            calc_valid;
    cvdf_pkg::disp_t calc_data;
    logic            calc_take;

    cvdf_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .frame_id        (frame_id),
        .data_byte_zero  (data_byte_zero),
        .data_byte_one   (data_byte_one),
        .data_byte_six   (data_byte_six),
        .data_byte_seven (data_byte_seven),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_push          (q_push),
        .q_data          (q_wdata),
        .q_full          (q_full)
    );

    cvdf_queue
    #(
        .Depth (QueueDepth)
    )
    u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    cvdf_calc u_calc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_data   (q_rdata),
        .in_pop    (q_pop),
        .out_valid (calc_valid),
        .out_data  (calc_data),
        .out_take  (calc_take)
    );

    cvdf_emit u_emit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (calc_valid),
        .in_data      (calc_data),
        .in_take      (calc_take),
        .empty        (empty),
        .pop          (pop),
        .display_port (display_port),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

endmodule
